// ===== rtl/core/tcce_pkg.sv =====
// Shared types and constants for the text console cursor engine.
package tcce_pkg;

    // Display command codes
    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_MOVE  = 2'd1,
        KIND_CLEAR = 2'd2
    } t_kind;

    // Configuration register indexes
    localparam logic [1:0] CFG_COLUMNS  = 2'd0;
    localparam logic [1:0] CFG_ROWS     = 2'd1;
    localparam logic [1:0] CFG_FG_COLOR = 2'd2;
    localparam logic [1:0] CFG_BG_COLOR = 2'd3;

    // Register reset values
    localparam logic [7:0] COLUMNS_RST  = 8'd80;
    localparam logic [7:0] ROWS_RST     = 8'd25;
    localparam logic [3:0] FG_COLOR_RST = 4'd15;
    localparam logic [3:0] BG_COLOR_RST = 4'd0;

    // Control characters
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [8:0] TAB_STEP = 9'd4;

    // Input mode codes
    localparam logic MODE_PUT   = 1'b0;
    localparam logic MODE_CLEAR = 1'b1;

    // Largest number of commands one item can cause
    localparam int MAX_CMDS = 3;

    typedef struct packed {
        logic [7:0] columns;
        logic [7:0] rows;
        logic [3:0] fg_color;
        logic [3:0] bg_color;
    } t_cfg;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] cell_char;
        logic [3:0] fore;
        logic [3:0] back;
        logic [7:0] col;
        logic [7:0] row;
        logic       last;
    } t_cmd;

    // Result of one item: commands in issue order, count and new cursor
    typedef struct packed {
        t_cmd [MAX_CMDS-1:0] cmds;
        logic [1:0]          count;
        logic [7:0]          new_col;
        logic [7:0]          new_row;
    } t_step_res;

endpackage

// ===== rtl/core/tcce_cfg_regs.sv =====
// Configuration register bank for the text console cursor engine.
module tcce_cfg_regs
    import tcce_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_wdata,
    output t_cfg       o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Decode the register write
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_COLUMNS:  n_cfg.columns  = i_cfg_wdata;
                CFG_ROWS:     n_cfg.rows     = i_cfg_wdata;
                CFG_FG_COLOR: n_cfg.fg_color = i_cfg_wdata[3:0];
                CFG_BG_COLOR: n_cfg.bg_color = i_cfg_wdata[3:0];
                default:      n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.columns  <= COLUMNS_RST;
            r_cfg.rows     <= ROWS_RST;
            r_cfg.fg_color <= FG_COLOR_RST;
            r_cfg.bg_color <= BG_COLOR_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/core/tcce_step.sv =====
// Cursor update and command generation for one input item.
module tcce_step
    import tcce_pkg::*;
(
    input  logic       i_mode,
    input  logic [7:0] i_ch,
    input  logic [7:0] i_cur_col,
    input  logic [7:0] i_cur_row,
    input  t_cfg       i_cfg,
    output t_step_res  o_res
);

    logic [8:0] c;
    logic [8:0] r;
    logic       is_write;
    logic       wrap;
    logic       clr;
    t_cmd       wr_cmd;
    t_cmd       mv_cmd;
    t_cmd       clr_cmd;

    // Cursor motion; column and row carry one extra bit for overflow
    always_comb begin
        c        = {1'b0, i_cur_col};
        r        = {1'b0, i_cur_row};
        is_write = 1'b0;
        unique case (i_ch)
            CH_LF: begin
                c = '0;
                r = r + 9'd1;
            end
            CH_CR: begin
                c = '0;
            end
            CH_BS: begin
                if (c != '0) begin
                    c = c - 9'd1;
                end
            end
            CH_TAB: begin
                c = c + TAB_STEP;
            end
            default: begin
                is_write = 1'b1;
                c        = c + 9'd1;
            end
        endcase
        // Column wrap, then bottom-of-screen check
        wrap = (c >= {1'b0, i_cfg.columns});
        if (wrap) begin
            c = '0;
            r = r + 9'd1;
        end
        clr = (r >= {1'b0, i_cfg.rows});
    end

    // Candidate commands
    always_comb begin
        wr_cmd.kind      = KIND_WRITE;
        wr_cmd.cell_char = i_ch;
        wr_cmd.fore      = i_cfg.fg_color;
        wr_cmd.back      = i_cfg.bg_color;
        wr_cmd.col       = i_cur_col;
        wr_cmd.row       = i_cur_row;
        wr_cmd.last      = 1'b0;

        mv_cmd.kind      = KIND_MOVE;
        mv_cmd.cell_char = '0;
        mv_cmd.fore      = i_cfg.fg_color;
        mv_cmd.back      = i_cfg.bg_color;
        mv_cmd.col       = c[7:0];
        mv_cmd.row       = r[7:0];
        mv_cmd.last      = 1'b0;

        clr_cmd.kind      = KIND_CLEAR;
        clr_cmd.cell_char = '0;
        clr_cmd.fore      = i_cfg.fg_color;
        clr_cmd.back      = i_cfg.bg_color;
        clr_cmd.col       = '0;
        clr_cmd.row       = '0;
        clr_cmd.last      = 1'b0;
    end

    // Order the commands and mark the final one
    always_comb begin
        o_res = '0;
        if (i_mode == MODE_CLEAR) begin
            o_res.cmds[0] = clr_cmd;
            o_res.count   = 2'd1;
            o_res.new_col = '0;
            o_res.new_row = '0;
        end else begin
            o_res.cmds[0] = is_write ? wr_cmd : mv_cmd;
            o_res.cmds[1] = is_write ? mv_cmd : clr_cmd;
            o_res.cmds[2] = clr_cmd;
            o_res.count   = 2'd1 + {1'b0, is_write} + {1'b0, clr};
            o_res.new_col = clr ? 8'd0 : c[7:0];
            o_res.new_row = clr ? 8'd0 : r[7:0];
        end
        for (int i = 0; i < MAX_CMDS; i++) begin
            o_res.cmds[i].last = (2'(i) == (o_res.count - 2'd1));
        end
    end

endmodule

// ===== rtl/core/tcce_cmd_buf.sv =====
// Result register that issues the commands of one item, one per cycle while the receiver is ready.
module tcce_cmd_buf
    import tcce_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  t_step_res  i_res,
    output logic       o_can_load,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [31:0] m_axis_tdata,  // cell_char, fore, back, col, row
    output logic [1:0] m_axis_tuser,   // kind
    output logic       m_axis_tlast
);

    t_cmd [MAX_CMDS-1:0] r_cmds;
    t_cmd [MAX_CMDS-1:0] n_cmds;
    logic [1:0]          r_left;
    logic [1:0]          n_left;
    logic                take;

    assign take       = (r_left != 2'd0) && m_axis_tready;
    assign o_can_load = (r_left == 2'd0) || ((r_left == 2'd1) && m_axis_tready);

    // Load a fresh set or shift toward the head on each transaction
    always_comb begin
        n_cmds = r_cmds;
        n_left = r_left;
        if (i_load) begin
            n_cmds = i_res.cmds;
            n_left = i_res.count;
        end else if (take) begin
            for (int i = 0; i < MAX_CMDS - 1; i++) begin
                n_cmds[i] = r_cmds[i+1];
            end
            n_left = r_left - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else begin
            r_left <= n_left;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmds <= n_cmds;
    end

    assign m_axis_tvalid = (r_left != 2'd0);
    assign m_axis_tdata  = {r_cmds[0].row, r_cmds[0].col, r_cmds[0].back,
                            r_cmds[0].fore, r_cmds[0].cell_char};
    assign m_axis_tuser  = r_cmds[0].kind;
    assign m_axis_tlast  = r_cmds[0].last;

endmodule

// ===== rtl/core/text_console_cursor_engine_unit.sv =====
// Top level of the text console cursor engine.
//
//  Channel  Direction  Payload
//  s_axis   in         tuser = mode, tdata = ch
//  m_axis   out        tuser = kind, tdata = cell_char/fore/back/col/row, tlast = last
//  cfg      in         i_cfg_index selects columns/rows/fg_color/bg_color
//
// An accepted item sits in the input register, is turned into one to three
// commands by combinational logic and moves into the result register when
// that register can load. The result register issues one command per cycle
// while the output is ready; a printable character causing a screen clear
// gives the three-command case. A stalled output holds the result register,
// and the input register still takes one more item.
// Synchronous active-low reset empties both registers and homes the cursor.
module text_console_cursor_engine_unit
    import tcce_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // ch
    input  logic        s_axis_tuser,   // mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // cell_char, fore, back, col, row
    output logic [1:0]  m_axis_tuser,   // kind
    output logic        m_axis_tlast
);

    t_cfg      cfg;
    t_step_res res;
    logic      buf_can_load;
    logic      s_take;
    logic      move;

    logic       r_in_valid;
    logic       n_in_valid;
    logic       r_in_mode;
    logic [7:0] r_in_ch;
    logic [7:0] r_cur_col;
    logic [7:0] r_cur_row;

    tcce_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    // Input register handshake
    assign s_axis_tready = !r_in_valid || buf_can_load;
    assign s_take        = s_axis_tvalid && s_axis_tready;
    assign move          = r_in_valid && buf_can_load;

    always_comb begin
        n_in_valid = r_in_valid;
        if (s_take) begin
            n_in_valid = 1'b1;
        end else if (move) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_cur_col  <= '0;
            r_cur_row  <= '0;
        end else begin
            r_in_valid <= n_in_valid;
            if (move) begin
                r_cur_col <= res.new_col;
                r_cur_row <= res.new_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_take) begin
            r_in_mode <= s_axis_tuser;
            r_in_ch   <= s_axis_tdata;
        end
    end

    tcce_step u_step (
        .i_mode    (r_in_mode),
        .i_ch      (r_in_ch),
        .i_cur_col (r_cur_col),
        .i_cur_row (r_cur_row),
        .i_cfg     (cfg),
        .o_res     (res)
    );

    tcce_cmd_buf u_buf (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (move),
        .i_res         (res),
        .o_can_load    (buf_can_load),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// ===== sim/tb_text_console_cursor_engine_unit.sv =====
// Self-checking testbench for the console cursor engine: directed table, random phases.
`timescale 1ns / 100ps

module tb_text_console_cursor_engine_unit;
    import tcce_pkg::*;

    // Clock and DUT ports
    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [1:0]  i_cfg_index;
    logic [7:0]  i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // ch
    logic        s_axis_tuser;   // mode
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // cell_char, fore, back, col, row
    logic [1:0]  m_axis_tuser;   // kind
    logic        m_axis_tlast;

    text_console_cursor_engine_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Shadow screen settings and cursor
    logic [7:0] scr_cols;
    logic [7:0] scr_rows;
    logic [3:0] ink_fg;
    logic [3:0] ink_bg;
    logic [7:0] cur_col;
    logic [7:0] cur_row;

    // Display commands still owed by the DUT, oldest first
    t_cmd pending_cmds[$];

    int n_mismatch = 0;
    int snd_idle_pct = 0;
    int rcv_idle_pct = 0;
    bit stall_go = 1'b0;
    int stall_left = 0;

    // One row of the directed plan: a register write or an input transaction
    typedef struct packed {
        logic        is_cfg;
        logic [1:0]  idx;
        logic [7:0]  val;
        logic        mode;
        logic [7:0]  ch;
        logic [1:0]  n_typed;
        t_cmd [2:0]  typed;
    } t_plan_row;

    t_plan_row plan[$];

    // Clock, 8 ns period
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic t_cmd mk_cmd(t_kind kind, logic [7:0] chr, logic [3:0] fore,
                                    logic [3:0] back, logic [7:0] col, logic [7:0] row,
                                    logic last);
        t_cmd c;
        c.kind      = kind;
        c.cell_char = chr;
        c.fore      = fore;
        c.back      = back;
        c.col       = col;
        c.row       = row;
        c.last      = last;
        return c;
    endfunction

    // Commands for one item; advances the shadow cursor
    function automatic logic [1:0] console_step(input logic mode, input logic [7:0] ch,
                                                output t_cmd [2:0] cmds);
        logic [8:0] c;
        logic [8:0] r;
        logic [1:0] n;
        c    = {1'b0, cur_col};
        r    = {1'b0, cur_row};
        n    = 2'd0;
        cmds = '0;
        if (mode == MODE_CLEAR) begin
            cmds[0] = mk_cmd(KIND_CLEAR, 8'h00, ink_fg, ink_bg, 8'd0, 8'd0, 1'b1);
            cur_col = 8'd0;
            cur_row = 8'd0;
            return 2'd1;
        end
        case (ch)
            CH_LF: begin
                c = 9'd0;
                r = r + 9'd1;
            end
            CH_CR: c = 9'd0;
            CH_BS: if (c != 9'd0) c = c - 9'd1;
            CH_TAB: c = c + TAB_STEP;
            default: begin
                cmds[n] = mk_cmd(KIND_WRITE, ch, ink_fg, ink_bg, c[7:0], r[7:0], 1'b0);
                n = n + 2'd1;
                c = c + 9'd1;
            end
        endcase
        // column wrap
        if (c >= {1'b0, scr_cols}) begin
            c = 9'd0;
            r = r + 9'd1;
        end
        cmds[n] = mk_cmd(KIND_MOVE, 8'h00, ink_fg, ink_bg, c[7:0], r[7:0], 1'b0);
        n = n + 2'd1;
        // off the bottom: clear and home
        if (r >= {1'b0, scr_rows}) begin
            cmds[n] = mk_cmd(KIND_CLEAR, 8'h00, ink_fg, ink_bg, 8'd0, 8'd0, 1'b0);
            n = n + 2'd1;
            c = 9'd0;
            r = 9'd0;
        end
        cmds[n - 2'd1].last = 1'b1;
        cur_col = c[7:0];
        cur_row = r[7:0];
        return n;
    endfunction

    task automatic report_miss(string what, logic [31:0] got, logic [31:0] want);
        if (n_mismatch < 40)
            $display("%0t ns: %s got 0x%0h want 0x%0h", $time, what, got, want);
        n_mismatch++;
    endtask

    // Offer one transaction; on acceptance queue what it should cause
    task automatic put_item(logic mode, logic [7:0] ch, logic [1:0] n_typed = 2'd0,
                            t_cmd [2:0] typed = '0);
        t_cmd [2:0] cmds;
        logic [1:0] n;
        @(negedge i_clk);
        while (snd_idle_pct != 0 && $urandom_range(0, 99) < snd_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = mode;
        s_axis_tdata  = ch;
        do @(posedge i_clk); while (!s_axis_tready);
        n = console_step(mode, ch, cmds);
        if (n_typed != 2'd0) begin
            cmds = typed;
            n    = n_typed;
        end
        for (int k = 0; k < n; k++) pending_cmds.push_back(cmds[k]);
    endtask

    // Stop offering and let every owed command come out
    task automatic settle();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending_cmds.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [7:0] val);
        @(negedge i_clk);
        i_cfg_wr_en = 1'b1;
        i_cfg_index = idx;
        i_cfg_wdata = val;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
        case (idx)
            CFG_COLUMNS:  scr_cols = val;
            CFG_ROWS:     scr_rows = val;
            CFG_FG_COLOR: ink_fg   = val[3:0];
            CFG_BG_COLOR: ink_bg   = val[3:0];
            default: ;
        endcase
    endtask

    task automatic set_screen(logic [7:0] cols, logic [7:0] rows, logic [3:0] fg,
                              logic [3:0] bg);
        cfg_write(CFG_COLUMNS, cols);
        cfg_write(CFG_ROWS, rows);
        cfg_write(CFG_FG_COLOR, {4'd0, fg});
        cfg_write(CFG_BG_COLOR, {4'd0, bg});
    endtask

    task automatic set_idling(int snd_pct, int rcv_pct);
        @(posedge i_clk);
        snd_idle_pct = snd_pct;
        rcv_idle_pct = rcv_pct;
    endtask

    // General random item: some clears, many control bytes, any byte
    task automatic put_random();
        logic [7:0] ctl [4];
        int pick;
        ctl  = '{CH_LF, CH_CR, CH_BS, CH_TAB};
        pick = $urandom_range(0, 99);
        if (pick < 10)
            put_item(MODE_CLEAR, 8'($urandom_range(0, 255)));
        else if (pick < 50)
            put_item(MODE_PUT, ctl[$urandom_range(0, 3)]);
        else
            put_item(MODE_PUT, 8'($urandom_range(0, 255)));
    endtask

    function automatic logic [7:0] pick_dim();
        case ($urandom_range(0, 4))
            0: return 8'd0;
            1: return 8'd1;
            2: return 8'd255;
            default: return 8'($urandom_range(2, 30));
        endcase
    endfunction

    function automatic void add_cfg(logic [1:0] idx, logic [7:0] val);
        t_plan_row p;
        p        = '0;
        p.is_cfg = 1'b1;
        p.idx    = idx;
        p.val    = val;
        plan.push_back(p);
    endfunction

    function automatic void add_item(logic mode, logic [7:0] ch, logic [1:0] n = 2'd0,
                                     t_cmd c0 = '0, t_cmd c1 = '0);
        t_plan_row p;
        p          = '0;
        p.mode     = mode;
        p.ch       = ch;
        p.n_typed  = n;
        p.typed[0] = c0;
        p.typed[1] = c1;
        plan.push_back(p);
    endfunction

    // Receiver: random tready, with a long hold on request
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_go) begin
                stall_go   = 1'b0;
                stall_left = 60;
            end
            if (stall_left > 0) begin
                m_axis_tready = 1'b0;
                stall_left--;
            end else begin
                m_axis_tready = ($urandom_range(0, 99) >= rcv_idle_pct);
            end
        end
    end

    // Output check against the oldest owed command
    always @(posedge i_clk) begin
        t_cmd want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_cmds.size() == 0) begin
                report_miss("command with none owed, tdata", m_axis_tdata, 32'd0);
            end else begin
                want = pending_cmds.pop_front();
                if (m_axis_tuser != want.kind)
                    report_miss("kind", 32'(m_axis_tuser), 32'(want.kind));
                if (m_axis_tdata[7:0] != want.cell_char)
                    report_miss("cell_char", 32'(m_axis_tdata[7:0]), 32'(want.cell_char));
                if (m_axis_tdata[11:8] != want.fore)
                    report_miss("fore", 32'(m_axis_tdata[11:8]), 32'(want.fore));
                if (m_axis_tdata[15:12] != want.back)
                    report_miss("back", 32'(m_axis_tdata[15:12]), 32'(want.back));
                if (m_axis_tdata[23:16] != want.col)
                    report_miss("col", 32'(m_axis_tdata[23:16]), 32'(want.col));
                if (m_axis_tdata[31:24] != want.row)
                    report_miss("row", 32'(m_axis_tdata[31:24]), 32'(want.row));
                if (m_axis_tlast != want.last)
                    report_miss("last", 32'(m_axis_tlast), 32'(want.last));
            end
        end
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("text_console_cursor_engine_unit: mismatch");
        $finish;
    end

    // Main sequence
    initial begin
        logic [7:0] ch;
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_index   = CFG_COLUMNS;
        i_cfg_wdata   = 8'd0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'd0;
        s_axis_tuser  = MODE_PUT;
        scr_cols      = COLUMNS_RST;
        scr_rows      = ROWS_RST;
        ink_fg        = FG_COLOR_RST;
        ink_bg        = BG_COLOR_RST;
        cur_col       = 8'd0;
        cur_row       = 8'd0;

        // Directed plan, reset settings first
        add_item(MODE_CLEAR, 8'hFF, 2'd1,
                 mk_cmd(KIND_CLEAR, 8'h00, FG_COLOR_RST, BG_COLOR_RST, 8'd0, 8'd0, 1'b1));
        add_item(MODE_PUT, 8'h41, 2'd2,
                 mk_cmd(KIND_WRITE, 8'h41, FG_COLOR_RST, BG_COLOR_RST, 8'd0, 8'd0, 1'b0),
                 mk_cmd(KIND_MOVE, 8'h00, FG_COLOR_RST, BG_COLOR_RST, 8'd1, 8'd0, 1'b1));
        add_item(MODE_PUT, CH_CR, 2'd1,
                 mk_cmd(KIND_MOVE, 8'h00, FG_COLOR_RST, BG_COLOR_RST, 8'd0, 8'd0, 1'b1));
        add_item(MODE_PUT, CH_TAB, 2'd1,
                 mk_cmd(KIND_MOVE, 8'h00, FG_COLOR_RST, BG_COLOR_RST, 8'd4, 8'd0, 1'b1));
        add_item(MODE_PUT, CH_BS, 2'd1,
                 mk_cmd(KIND_MOVE, 8'h00, FG_COLOR_RST, BG_COLOR_RST, 8'd3, 8'd0, 1'b1));
        add_item(MODE_PUT, CH_LF, 2'd1,
                 mk_cmd(KIND_MOVE, 8'h00, FG_COLOR_RST, BG_COLOR_RST, 8'd0, 8'd1, 1'b1));
        // backspace at column 0 stays put
        add_item(MODE_PUT, CH_BS, 2'd1,
                 mk_cmd(KIND_MOVE, 8'h00, FG_COLOR_RST, BG_COLOR_RST, 8'd0, 8'd1, 1'b1));
        add_item(MODE_PUT, 8'h00);
        add_item(MODE_PUT, 8'hFF);
        add_item(MODE_PUT, CH_TAB);
        // shrink the screen under the cursor
        add_cfg(CFG_COLUMNS, 8'd1);
        add_cfg(CFG_ROWS, 8'd2);
        add_cfg(CFG_FG_COLOR, 8'd0);
        add_cfg(CFG_BG_COLOR, 8'd15);
        add_item(MODE_PUT, 8'h78);
        add_item(MODE_CLEAR, 8'h00, 2'd1,
                 mk_cmd(KIND_CLEAR, 8'h00, 4'd0, 4'd15, 8'd0, 8'd0, 1'b1));
        add_item(MODE_PUT, 8'h42);
        add_item(MODE_PUT, CH_BS);
        add_item(MODE_PUT, CH_LF);
        // zero columns and zero rows
        add_cfg(CFG_COLUMNS, 8'd0);
        add_cfg(CFG_ROWS, 8'd0);
        add_item(MODE_PUT, 8'h43);
        add_item(MODE_PUT, CH_CR);
        add_item(MODE_CLEAR, 8'h55);
        // largest screen
        add_cfg(CFG_COLUMNS, 8'd255);
        add_cfg(CFG_ROWS, 8'd255);
        add_cfg(CFG_FG_COLOR, 8'd9);
        add_cfg(CFG_BG_COLOR, 8'd6);
        add_item(MODE_PUT, CH_TAB);
        add_item(MODE_PUT, 8'h44);
        add_item(MODE_PUT, CH_LF);
        add_item(MODE_PUT, 8'h7F);
        add_item(MODE_PUT, CH_BS);

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        set_idling(7, 78);
        foreach (plan[i]) begin
            if (plan[i].is_cfg) begin
                settle();
                cfg_write(plan[i].idx, plan[i].val);
            end else begin
                put_item(plan[i].mode, plan[i].ch, plan[i].n_typed, plan[i].typed);
            end
        end

        // Small screens, random traffic; sender waits out the queue halfway
        settle();
        set_screen(8'($urandom_range(1, 12)), 8'($urandom_range(1, 6)),
                   4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
        repeat (15) put_random();
        settle();
        repeat (15) put_random();

        // Wide screen, mostly tabs to push the column high
        settle();
        set_idling(78, 7);
        set_screen(8'd255, 8'd255, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
        repeat (20) begin
            case ($urandom_range(0, 9))
                0: put_item(MODE_PUT, CH_BS);
                1, 2: put_item(MODE_PUT, 8'($urandom_range(0, 255)));
                default: put_item(MODE_PUT, CH_TAB);
            endcase
        end

        // Zero columns: every item drops a row, a newline two; walk down to row 254,
        // then a newline lands past row 255; receiver held off at the start
        settle();
        set_idling(0, 0);
        set_screen(8'd0, 8'd255, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
        @(posedge i_clk);
        stall_go = 1'b1;
        while (cur_row < 8'd254) begin
            if (cur_row == 8'd253 || $urandom_range(0, 7) == 0) begin
                ch = 8'($urandom_range(0, 255));
                if (ch == CH_LF) ch = CH_CR;
                put_item(MODE_PUT, ch);
            end else begin
                put_item(MODE_PUT, CH_LF);
            end
        end
        put_item(MODE_PUT, CH_LF);

        // Random screen sizes including the edges
        settle();
        set_screen(pick_dim(), pick_dim(), 4'($urandom_range(0, 15)),
                   4'($urandom_range(0, 15)));
        repeat (20) put_random();

        settle();
        repeat (20) @(posedge i_clk);
        if (n_mismatch == 0) begin
            $display("text_console_cursor_engine_unit: match");
        end else begin
            $display("text_console_cursor_engine_unit: mismatch");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/tcce_pkg.sv
rtl/core/tcce_cfg_regs.sv
rtl/core/tcce_step.sv
rtl/core/tcce_cmd_buf.sv
rtl/core/text_console_cursor_engine_unit.sv
sim/tb_text_console_cursor_engine_unit.sv
